// ===== rtl/kdeg_pkg.sv =====
// shared types, constants and codes for the key debounce event generator
package kdeg_pkg;

  localparam int NUM_KEYS  = 32;
  localparam int KEY_W     = (NUM_KEYS > 1) ? $clog2(NUM_KEYS) : 1;
  localparam int KEY_IDX_W = 5;
  localparam int TIME_W    = 32;
  localparam int CFG_W     = 16;
  localparam int CFG_IDX_W = 3;
  localparam int DPK_W     = 6;
  localparam int RCNT_W    = 2;

  typedef logic [KEY_W-1:0]  addr_t;
  typedef logic [TIME_W-1:0] time_t;

  typedef enum logic [2:0] {
    EV_PRESS        = 3'd0,
    EV_DOUBLE       = 3'd1,
    EV_RELEASE      = 3'd2,
    EV_RELEASE_HOLD = 3'd3,
    EV_HOLD         = 3'd4
  } event_kind_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_DEBOUNCE    = 3'd0,
    REG_DP_WINDOW   = 3'd1,
    REG_HOLD_TIME   = 3'd2,
    REG_REPEAT_TIME = 3'd3,
    REG_DHOLD_EN    = 3'd4,
    REG_DP_KEYS     = 3'd5
  } cfg_reg_t;

  typedef struct packed {
    logic [CFG_W-1:0] debounce_time;
    logic [CFG_W-1:0] double_press_window;
    logic [CFG_W-1:0] hold_time;
    logic [CFG_W-1:0] repeat_time;
    logic             double_hold_enable;
    logic [DPK_W-1:0] double_press_keys;
  } cfg_t;

  typedef struct packed {
    logic              stable_level;
    logic              holding;
    time_t             last_change;
    time_t             press_start;
    time_t             hold_start;
    logic [RCNT_W-1:0] repeat_count;
  } key_state_t;

  typedef struct packed {
    logic        valid;
    event_kind_t kind;
    time_t       duration;
  } event_t;

endpackage

// ===== rtl/kdeg_if.sv =====
// sample and event channel interfaces
interface kdeg_sample_if;
  import kdeg_pkg::*;
  logic                 valid;
  logic                 ready;
  logic [KEY_IDX_W-1:0] key_index;
  logic                 key_down;
  time_t                now_ms;
  modport source (output valid, key_index, key_down, now_ms, input ready);
  modport sink (input valid, key_index, key_down, now_ms, output ready);
endinterface

interface kdeg_event_if;
  import kdeg_pkg::*;
  logic                 valid;
  logic                 ready;
  logic [KEY_IDX_W-1:0] event_key;
  event_kind_t          event_kind;
  time_t                event_time;
  time_t                hold_duration;
  modport source (output valid, event_key, event_kind, event_time, hold_duration,
                  input ready);
  modport sink (input valid, event_key, event_kind, event_time, hold_duration,
                output ready);
endinterface

// ===== rtl/kdeg_cfg_regs.sv =====
// configuration register bank
module kdeg_cfg_regs (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           cfg_write,
  input  logic [kdeg_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [kdeg_pkg::CFG_W-1:0]     cfg_data,
  output kdeg_pkg::cfg_t                 cfg
);
  import kdeg_pkg::*;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.debounce_time       <= CFG_W'(20);
      cfg.double_press_window <= CFG_W'(300);
      cfg.hold_time           <= CFG_W'(500);
      cfg.repeat_time         <= CFG_W'(100);
      cfg.double_hold_enable  <= 1'b0;
      cfg.double_press_keys   <= DPK_W'(5);
    end else if (cfg_write) begin
      case (cfg_reg_t'(cfg_index))
        REG_DEBOUNCE:    cfg.debounce_time       <= cfg_data;
        REG_DP_WINDOW:   cfg.double_press_window <= cfg_data;
        REG_HOLD_TIME:   cfg.hold_time           <= cfg_data;
        REG_REPEAT_TIME: cfg.repeat_time         <= cfg_data;
        REG_DHOLD_EN:    cfg.double_hold_enable  <= cfg_data[0];
        REG_DP_KEYS:     cfg.double_press_keys   <= cfg_data[DPK_W-1:0];
        default: ;
      endcase
    end
  end

endmodule

// ===== rtl/kdeg_state_mem.sv =====
// per-key state memory with valid bits and write-to-read forwarding
module kdeg_state_mem (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 rd_en,
  input  kdeg_pkg::addr_t      rd_addr,
  input  logic                 wr_en,
  input  kdeg_pkg::addr_t      wr_addr,
  input  kdeg_pkg::key_state_t wr_data,
  output kdeg_pkg::key_state_t rd_state
);
  import kdeg_pkg::*;

  key_state_t            mem [NUM_KEYS];
  logic [NUM_KEYS-1:0]   vld;
  key_state_t            mem_q;
  key_state_t            fwd_data;
  logic                  vld_q;
  logic                  fwd_hit;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      mem_q    <= mem[rd_addr];
      fwd_data <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vld     <= '0;
      vld_q   <= 1'b0;
      fwd_hit <= 1'b0;
    end else begin
      if (wr_en) begin
        vld[wr_addr] <= 1'b1;
      end
      if (rd_en) begin
        vld_q   <= vld[rd_addr];
        // write lands on the same edge as the read, so take the new value
        fwd_hit <= wr_en && (wr_addr == rd_addr);
      end
    end
  end

  // entries never written since reset read as all zero
  always_comb begin
    if (fwd_hit) begin
      rd_state = fwd_data;
    end else if (vld_q) begin
      rd_state = mem_q;
    end else begin
      rd_state = '0;
    end
  end

endmodule

// ===== rtl/kdeg_event_logic.sv =====
// debounce, press, release and hold decisions for one sample
module kdeg_event_logic (
  input  kdeg_pkg::cfg_t                 cfg,
  input  logic [kdeg_pkg::KEY_IDX_W-1:0] key,
  input  logic                           down,
  input  kdeg_pkg::time_t                now,
  input  kdeg_pkg::key_state_t           state,
  output kdeg_pkg::key_state_t           state_next,
  output kdeg_pkg::event_t               ev
);
  import kdeg_pkg::*;

  time_t            since_change;
  time_t            since_press;
  time_t            since_hold;
  logic [CFG_W-1:0] interval;
  logic             long_wait;

  assign since_change = now - state.last_change;
  assign since_press  = now - state.press_start;
  assign since_hold   = now - state.hold_start;

  assign long_wait = (state.repeat_count == '0) ||
                     (cfg.double_hold_enable && (state.repeat_count == RCNT_W'(1)));
  assign interval  = long_wait ? cfg.hold_time : cfg.repeat_time;

  always_comb begin
    state_next  = state;
    ev.valid    = 1'b0;
    ev.kind     = EV_PRESS;
    ev.duration = '0;
    if (down != state.stable_level) begin
      if (since_change >= TIME_W'(cfg.debounce_time)) begin
        state_next.stable_level = down;
        state_next.last_change  = now;
        ev.valid                = 1'b1;
        if (down) begin
          if ((since_press < TIME_W'(cfg.double_press_window)) &&
              (DPK_W'(key) < cfg.double_press_keys)) begin
            ev.kind = EV_DOUBLE;
          end else begin
            ev.kind = EV_PRESS;
          end
          state_next.press_start = now;
        end else begin
          ev.kind                 = state.holding ? EV_RELEASE_HOLD : EV_RELEASE;
          state_next.holding      = 1'b0;
          state_next.repeat_count = '0;
        end
      end
    end else if (down && (since_press >= TIME_W'(interval))) begin
      ev.valid = 1'b1;
      ev.kind  = EV_HOLD;
      // first hold of a press starts the duration clock
      if (!state.holding) begin
        state_next.hold_start = now;
        ev.duration           = '0;
      end else begin
        ev.duration = since_hold;
      end
      state_next.holding     = 1'b1;
      state_next.press_start = now;
      if (state.repeat_count != '1) begin
        state_next.repeat_count = state.repeat_count + RCNT_W'(1);
      end
    end
  end

endmodule

// ===== rtl/key_debounce_event_generator.sv =====
// top level: key sample debouncer and press/hold event generator
//
// channel   dir  handshake     payload
// samples   in   valid/ready   key_index, key_down, now_ms
// events    out  valid/ready   event_key, event_kind, event_time, hold_duration
// cfg       in   cfg_write     cfg_index, cfg_data
//
// one sample per cycle unless events stall; an event leaves through the output register
// the per-key state memory is read on the transfer edge, updated and written back when
// the compute stage fires; a same-key write on a read edge is forwarded
// synchronous reset clears the per-key valid bits at once, no clearing pass
// a stalled event sits in the output register; the compute stage holds behind it
module key_debounce_event_generator (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           cfg_write,
  input  logic [kdeg_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [kdeg_pkg::CFG_W-1:0]     cfg_data,
  kdeg_sample_if.sink                    samples,
  kdeg_event_if.source                   events
);
  import kdeg_pkg::*;

  cfg_t                 cfg;
  key_state_t           rd_state;
  key_state_t           state_next;
  event_t               ev;
  logic                 accept;
  logic                 s1_valid;
  logic                 s1_fire;
  logic                 s1_in_range;
  logic                 wr_en;
  logic [KEY_IDX_W-1:0] s1_key;
  logic                 s1_down;
  time_t                s1_now;

  kdeg_cfg_regs u_cfg (
    .clk       (clk),
    .rst       (rst),
    .cfg_write (cfg_write),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cfg       (cfg)
  );

  assign accept        = samples.valid && samples.ready;
  assign s1_fire       = s1_valid && (!events.valid || events.ready);
  assign samples.ready = !s1_valid || s1_fire;
  assign s1_in_range   = 32'(s1_key) < 32'(NUM_KEYS);
  assign wr_en         = s1_fire && s1_in_range;

  kdeg_state_mem u_mem (
    .clk      (clk),
    .rst      (rst),
    .rd_en    (accept),
    .rd_addr  (addr_t'(samples.key_index)),
    .wr_en    (wr_en),
    .wr_addr  (addr_t'(s1_key)),
    .wr_data  (state_next),
    .rd_state (rd_state)
  );

  kdeg_event_logic u_logic (
    .cfg        (cfg),
    .key        (s1_key),
    .down       (s1_down),
    .now        (s1_now),
    .state      (rd_state),
    .state_next (state_next),
    .ev         (ev)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (accept) begin
      s1_valid <= 1'b1;
    end else if (s1_fire) begin
      s1_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      s1_key  <= samples.key_index;
      s1_down <= samples.key_down;
      s1_now  <= samples.now_ms;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      events.valid <= 1'b0;
    end else if (s1_fire && s1_in_range && ev.valid) begin
      events.valid <= 1'b1;
    end else if (events.ready) begin
      events.valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_fire && s1_in_range && ev.valid) begin
      events.event_key     <= s1_key;
      events.event_kind    <= ev.kind;
      events.event_time    <= s1_now;
      events.hold_duration <= ev.duration;
    end
  end

  // a blocked sample keeps its place and its key
  a_s1_hold: assert property (@(posedge clk) disable iff (rst)
    s1_valid && !s1_fire |=> s1_valid && $stable(s1_key))
    else $error("compute stage lost a stalled sample");

  // an event from the compute stage always reaches the output register
  a_ev_out: assert property (@(posedge clk) disable iff (rst)
    s1_fire && s1_in_range && ev.valid |=> events.valid && (events.event_key == $past(s1_key)))
    else $error("event not loaded into output register");

  // hold events carry a duration, other kinds carry zero
  a_dur: assert property (@(posedge clk) disable iff (rst)
    s1_valid && ev.valid && (ev.kind != EV_HOLD) |-> ev.duration == '0)
    else $error("non-hold event with nonzero duration");

  // no sample is taken while the compute stage is stuck
  a_no_take: assert property (@(posedge clk) disable iff (rst)
    s1_valid && events.valid && !events.ready |-> !accept)
    else $error("sample taken while compute stage stalled");

endmodule
